// File: sv/hpm_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the halfcomplex power/magnitude block.
package hpm_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int VALUE_W    = 48;
  localparam int ROOT_W     = 24;
  localparam int REM_W      = 26;
  localparam int SQRT_STEPS = 24;
  localparam int STEP_W     = 5;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_WRITE = 8'b0000_0010,
    ST_READ  = 8'b0000_0100,
    ST_MUL_R = 8'b0000_1000,
    ST_ADD   = 8'b0001_0000,
    ST_EDGE  = 8'b0010_0000,
    ST_SQRT  = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;        // latch the accepted sample and advance the frame position
    logic ram_we;      // store the latched real part
    logic ram_re;      // fetch the real part of the current bin
    logic mul_sample;  // product <= |sample|^2
    logic mul_real;    // sum <= product, product <= |real|^2
    logic acc_add;     // sum <= sum + product
    logic sqrt_clear;  // reset the root and remainder
    logic sqrt_step;   // one digit of the square root
    logic out_load;    // move the finished bin into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pos_edge;    // next word is r0 or the Nyquist real part
    logic pos_store;   // next word is a real part to be kept
    logic sqrt_last;   // the current square-root step is the final one
    logic out_busy;    // output register full and not being drained
    logic mag_mode;    // magnitude selected
  } status_t;

  function automatic logic [SAMPLE_W-1:0] abs_sample(input logic [SAMPLE_W-1:0] v);
    logic [SAMPLE_W-1:0] r;
    r = v[SAMPLE_W-1] ? (~v + SAMPLE_W'(1)) : v;
    return r;
  endfunction

endpackage

// File: sv/halfcomplex_power_magnitude.sv
`timescale 1ns / 1ps
// Top level of the halfcomplex power/magnitude spectrum block.
//
//  Channel   Direction  Payload                                   Marker
//  s_axis    in         tdata[23:0] sample (signed)               -
//  m_axis    out        tdata[47:0] bin_value, [+IW-1:48] index  tlast = bin 1
//  cfg       in         cfg_wdata_i output_mode (0 power, 1 mag)  cfg_we_i
//
// Steps per word: a stored real part goes IDLE, WRITE; DC and Nyquist go IDLE, EDGE, OUT;
// a bin in power mode goes IDLE, READ, MUL_R, ADD, OUT, and a bin in magnitude mode adds the
// one-digit-per-cycle square root (24 steps, SQRT) behind the RAM read and the shared squarer.
// A new word is taken while a finished bin waits in the output register; a bin that
// is ready while the previous one is still stalled holds the controller.
// Reset clears the frame position, the mode and the output valid; the real-part
// store is not cleared, since every entry is written before it is read in a frame.
module halfcomplex_power_magnitude #(
  parameter int FRAME_LEN = 1024,
  localparam int IW = $clog2(FRAME_LEN / 2 + 1),
  localparam int OW = ((hpm_pkg::VALUE_W + IW + 7) / 8) * 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [23:0]   s_axis_tdata_i,  // [23:0] sample
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [OW-1:0] m_axis_tdata_o,  // [47:0] bin_value, [48+IW-1:48] bin number
  output logic          m_axis_tlast_o,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i
);

  hpm_pkg::cmd_t              cmd;
  hpm_pkg::status_t           status;
  logic [hpm_pkg::VALUE_W-1:0] out_value;
  logic [IW-1:0]               out_index;

  hpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hpm_datapath #(
    .FRAME_LEN (FRAME_LEN)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .sample_i    (s_axis_tdata_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_value_o (out_value),
    .out_index_o (out_index),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = OW'({out_index, out_value});

endmodule

// File: sv/hpm_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module hpm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/hpm_datapath.sv
`timescale 1ns / 1ps
// Datapath: frame position, real-part store, squarer, adder, square root and output register.
module hpm_datapath #(
  parameter int FRAME_LEN = 1024,
  localparam int HALF = FRAME_LEN / 2,
  localparam int PW   = $clog2(FRAME_LEN),
  localparam int AW   = (HALF > 1) ? $clog2(HALF) : 1,
  localparam int IW   = $clog2(HALF + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hpm_pkg::cmd_t                cmd_i,
  output hpm_pkg::status_t             status_o,
  input  logic [hpm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [hpm_pkg::VALUE_W-1:0]  out_value_o,
  output logic [IW-1:0]                out_index_o,
  output logic                         out_last_o
);

  logic [PW-1:0]                pos_q, pos_d;
  logic                         mode_q;
  logic [hpm_pkg::SAMPLE_W-1:0] sample_q;
  logic [IW-1:0]                bin_q, bin_d;
  logic [AW-1:0]                waddr_q;
  logic                         edge_q;
  logic [hpm_pkg::VALUE_W-1:0]  prod_q, prod_d;
  logic [hpm_pkg::VALUE_W-1:0]  acc_q, acc_d;
  logic [hpm_pkg::REM_W-1:0]    rem_q, rem_d;
  logic [hpm_pkg::ROOT_W-1:0]   root_q, root_d;
  logic [hpm_pkg::STEP_W-1:0]   step_q;
  logic                         out_valid_q;
  logic [hpm_pkg::VALUE_W-1:0]  out_value_q, out_value_d;
  logic [IW-1:0]                out_index_q;
  logic                         out_last_q;

  logic [hpm_pkg::SAMPLE_W-1:0] ram_rdata;
  logic [hpm_pkg::SAMPLE_W-1:0] sample_abs;
  logic [hpm_pkg::SAMPLE_W-1:0] mul_op;
  logic [PW:0]                  mirror_bin;
  logic                         pos_edge;
  logic                         pos_store;
  logic [hpm_pkg::REM_W-1:0]    rem_shift;
  logic [hpm_pkg::REM_W-1:0]    trial;
  logic                         trial_ok;

  // Imaginary part at position p belongs to bin N - p.
  assign mirror_bin = (PW + 1)'(FRAME_LEN) - {1'b0, pos_q};
  assign pos_edge   = (pos_q == '0) || (pos_q == PW'(HALF));
  assign pos_store  = (pos_q != '0) && (pos_q < PW'(HALF));
  assign pos_d      = (pos_q == PW'(FRAME_LEN - 1)) ? '0 : pos_q + PW'(1);
  assign bin_d      = pos_edge ? IW'(pos_q) : IW'(mirror_bin);

  hpm_ram #(
    .WIDTH (hpm_pkg::SAMPLE_W),
    .DEPTH (HALF)
  ) u_real_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .waddr_i (waddr_q),
    .wdata_i (sample_q),
    .re_i    (cmd_i.ram_re),
    .raddr_i (bin_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign sample_abs = hpm_pkg::abs_sample(sample_q);
  assign mul_op     = cmd_i.mul_real ? hpm_pkg::abs_sample(ram_rdata) : sample_abs;
  assign prod_d     = hpm_pkg::VALUE_W'(mul_op) * hpm_pkg::VALUE_W'(mul_op);

  // Restoring square root: two radicand bits enter the remainder per step.
  assign rem_shift = {rem_q[hpm_pkg::REM_W-3:0], acc_q[hpm_pkg::VALUE_W-1 -: 2]};
  assign trial     = {root_q[hpm_pkg::ROOT_W-1:0], 2'b01};
  assign trial_ok  = rem_shift >= trial;

  always_comb begin
    acc_d  = acc_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (cmd_i.mul_real) begin
      acc_d = prod_q;
    end else if (cmd_i.acc_add) begin
      acc_d = acc_q + prod_q;
    end else if (cmd_i.sqrt_step) begin
      acc_d = {acc_q[hpm_pkg::VALUE_W-3:0], 2'b00};
    end
    if (cmd_i.sqrt_clear) begin
      rem_d  = '0;
      root_d = '0;
    end else if (cmd_i.sqrt_step) begin
      rem_d  = trial_ok ? (rem_shift - trial) : rem_shift;
      root_d = {root_q[hpm_pkg::ROOT_W-2:0], trial_ok};
    end
  end

  always_comb begin
    case ({edge_q, mode_q})
      2'b11:   out_value_d = hpm_pkg::VALUE_W'(sample_abs);
      2'b10:   out_value_d = prod_q;
      2'b01:   out_value_d = hpm_pkg::VALUE_W'(root_q);
      default: out_value_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      mode_q      <= 1'b0;
      edge_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (cmd_i.take) begin
        pos_q  <= pos_d;
        edge_q <= pos_edge;
      end
      if (cmd_i.sqrt_clear) begin
        step_q <= '0;
      end else if (cmd_i.sqrt_step) begin
        step_q <= step_q + hpm_pkg::STEP_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      sample_q <= sample_i;
      bin_q    <= bin_d;
      waddr_q  <= pos_q[AW-1:0];
    end
    if (cmd_i.mul_sample || cmd_i.mul_real) begin
      prod_q <= prod_d;
    end
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    if (cmd_i.out_load) begin
      out_value_q <= out_value_d;
      out_index_q <= bin_q;
      out_last_q  <= (bin_q == IW'(1));
    end
  end

  assign status_o.pos_edge  = pos_edge;
  assign status_o.pos_store = pos_store;
  assign status_o.sqrt_last = (step_q == hpm_pkg::STEP_W'(hpm_pkg::SQRT_STEPS - 1));
  assign status_o.out_busy  = out_valid_q && !out_ready_i;
  assign status_o.mag_mode  = mode_q;

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_index_o = out_index_q;
  assign out_last_o  = out_last_q;

  a_last_is_bin_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_q |-> out_index_q == IW'(1))
    else $error("last_bin flagged on a bin other than 1");

  a_sqrt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sqrt_step |-> step_q < hpm_pkg::STEP_W'(hpm_pkg::SQRT_STEPS))
    else $error("square root stepped past its final digit");

  a_magnitude_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !edge_q && mode_q && $rose(out_valid_q)
      |-> out_value_q[hpm_pkg::VALUE_W-1:hpm_pkg::ROOT_W] == '0)
    else $error("magnitude result wider than 24 bits");

endmodule

// File: sv/hpm_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences each accepted word through the datapath.
module hpm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  hpm_pkg::status_t status_i,
  output hpm_pkg::cmd_t    cmd_o
);

  hpm_pkg::state_e state_q, state_d;
  logic            take;

  assign in_ready_o = (state_q == hpm_pkg::ST_IDLE);
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      hpm_pkg::ST_IDLE: begin
        if (take) begin
          cmd_o.take = 1'b1;
          if (status_i.pos_edge) begin
            state_d = hpm_pkg::ST_EDGE;
          end else if (status_i.pos_store) begin
            state_d = hpm_pkg::ST_WRITE;
          end else begin
            state_d = hpm_pkg::ST_READ;
          end
        end
      end
      hpm_pkg::ST_WRITE: begin
        cmd_o.ram_we = 1'b1;
        state_d      = hpm_pkg::ST_IDLE;
      end
      hpm_pkg::ST_READ: begin
        cmd_o.ram_re     = 1'b1;
        cmd_o.mul_sample = 1'b1;
        state_d          = hpm_pkg::ST_MUL_R;
      end
      hpm_pkg::ST_MUL_R: begin
        cmd_o.mul_real = 1'b1;
        state_d        = hpm_pkg::ST_ADD;
      end
      hpm_pkg::ST_ADD: begin
        cmd_o.acc_add    = 1'b1;
        cmd_o.sqrt_clear = 1'b1;
        state_d          = status_i.mag_mode ? hpm_pkg::ST_SQRT : hpm_pkg::ST_OUT;
      end
      hpm_pkg::ST_EDGE: begin
        cmd_o.mul_sample = 1'b1;
        state_d          = hpm_pkg::ST_OUT;
      end
      hpm_pkg::ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (status_i.sqrt_last) begin
          state_d = hpm_pkg::ST_OUT;
        end
      end
      hpm_pkg::ST_OUT: begin
        // Hold the finished bin until the output register has room.
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = hpm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = hpm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hpm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_store_goes_to_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && status_i.pos_store |=> state_q == hpm_pkg::ST_WRITE)
    else $error("stored real part did not reach the write state");

  a_no_load_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !status_i.out_busy)
    else $error("output register overwritten while a result was waiting");

  a_sqrt_ends_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hpm_pkg::ST_SQRT && status_i.sqrt_last |=> state_q == hpm_pkg::ST_OUT)
    else $error("square root did not hand over to the output state");

endmodule
